/* rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and the digit-to-ASCII mapping of the radix digit
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

	// Field widths of the stream words
	localparam int VALUE_W     = 32;
	localparam int RADIX_W     = 5;
	localparam int CHAR_W      = 7;
	localparam int DIGIT_W     = 4;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 8;

	// Default number of value bits used
	localparam int VALUE_BITS_DEF = 32;

	// Quotient bits worked out per divider cycle
	localparam int DIV_STEP = 4;

	// Valid radix range
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	// ASCII anchors
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h41;
	localparam logic [DIGIT_W-1:0] DEC_BASE  = 4'd10;

	// Classification of one queued word
	typedef struct packed {
		logic               bad_radix;
		logic [RADIX_W-1:0] radix;
	} rdc_cls_t;

	// Digit 0..15 to '0'-'9' / 'A'-'F'
	function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
		if (d < DEC_BASE) begin
			return CHAR_ZERO + {3'b000, d};
		end else begin
			return CHAR_A + {3'b000, d - DEC_BASE};
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/rdc_ram.sv */
// ----------------------------------------------------------------------------
// rdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/rdc_front.sv */
// ----------------------------------------------------------------------------
// rdc_front
// Input side: takes words, checks the radix and queues value plus class in a
// two-entry queue for the conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_front
	import rdc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire  [S_TDATA_W-1:0]   s_tdata,   // value[31:0], radix[36:32], zero pad
	output logic                   q_valid,
	input  wire                    q_pop,
	output logic [VALUE_BITS-1:0]  q_value,
	output rdc_cls_t               q_cls
);

	logic [VALUE_BITS-1:0] val_q [2];
	rdc_cls_t              cls_q [2];
	logic                  wp_q;
	logic                  rp_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic [RADIX_W-1:0]    radix_in;
	rdc_cls_t              cls_in;

	// classify the incoming word
	assign radix_in         = s_tdata[VALUE_W +: RADIX_W];
	assign cls_in.radix     = radix_in;
	assign cls_in.bad_radix = !(radix_in inside {[RADIX_MIN:RADIX_MAX]});

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_value  = val_q[rp_q];
	assign q_cls    = cls_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			val_q[wp_q] <= VALUE_BITS'(s_tdata[VALUE_W-1:0]);
			cls_q[wp_q] <= cls_in;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop) begin
				rp_q <= !rp_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/rdc_back.sv */
// ----------------------------------------------------------------------------
// rdc_back
// Conversion engine: repeated division by the radix, four quotient bits per
// cycle, digits kept in a RAM, then read back most significant first into a
// registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_back
	import rdc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    q_valid,
	output logic                   q_pop,
	input  wire  [VALUE_BITS-1:0]  q_value,
	input  rdc_cls_t               q_cls,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata,   // digit_char[6:0], zero pad
	output logic                   m_tlast,   // last
	output logic                   m_tuser    // bad_radix
);

	localparam int NSTEPS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int PADW   = NSTEPS * DIV_STEP;
	localparam int SW     = $clog2(NSTEPS);
	localparam int DEPTH  = VALUE_BITS;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RD,
		ST_LD
	} state_t;

	state_t              st_q;
	logic [PADW-1:0]     dv_q;
	logic [DIGIT_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  rad_q;
	logic [SW-1:0]       stp_q;
	logic [CW-1:0]       cnt_q;
	logic [AW-1:0]       idx_q;
	logic [CHAR_W-1:0]   char_q;
	logic                vld_q;
	logic                last_q;
	logic                bad_q;

	logic [PADW-1:0]     dv_nx;
	logic [DIGIT_W-1:0]  rem_nx;
	logic [RADIX_W-1:0]  part;
	logic                out_free;
	logic                stp_last;
	logic                dig_we;
	logic                rd_en;
	logic [DIGIT_W-1:0]  rd_digit;

	assign out_free = !vld_q || m_tready;
	assign stp_last = (stp_q == SW'(NSTEPS - 1));
	assign q_pop    = (st_q == ST_IDLE) && q_valid && out_free;
	assign dig_we   = (st_q == ST_DIV) && stp_last;
	assign rd_en    = (st_q == ST_RD);

	// restoring division, DIV_STEP quotient bits per cycle
	always_comb begin
		rem_nx = rem_q;
		dv_nx  = dv_q;
		part   = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			part  = {rem_nx, dv_nx[PADW-1]};
			dv_nx = {dv_nx[PADW-2:0], 1'b0};
			if (part >= rad_q) begin
				part     = part - rad_q;
				dv_nx[0] = 1'b1;
			end
			rem_nx = part[DIGIT_W-1:0];
		end
	end

	// digit store, least significant digit at address 0
	rdc_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (dig_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rem_nx),
		.re    (rd_en),
		.raddr (idx_q),
		.rdata (rd_digit)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			dv_q   <= '0;
			rem_q  <= '0;
			rad_q  <= '0;
			stp_q  <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			char_q <= '0;
			vld_q  <= 1'b0;
			last_q <= 1'b0;
			bad_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				vld_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_cls.bad_radix) begin
							// error word: single result
							char_q <= '0;
							last_q <= 1'b1;
							bad_q  <= 1'b1;
							vld_q  <= 1'b1;
						end else begin
							dv_q  <= PADW'(q_value);
							rem_q <= '0;
							rad_q <= q_cls.radix;
							stp_q <= '0;
							cnt_q <= '0;
							st_q  <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					dv_q  <= dv_nx;
					rem_q <= rem_nx;
					stp_q <= stp_q + SW'(1);
					if (stp_last) begin
						// digit written this cycle; start next division or read back
						cnt_q <= cnt_q + CW'(1);
						rem_q <= '0;
						stp_q <= '0;
						if ((dv_nx == '0) || (cnt_q + CW'(1) == CW'(DEPTH))) begin
							idx_q <= cnt_q[AW-1:0];
							st_q  <= ST_RD;
						end
					end
				end
				ST_RD: begin
					st_q <= ST_LD;
				end
				ST_LD: begin
					if (out_free) begin
						char_q <= to_ascii(rd_digit);
						last_q <= (idx_q == '0);
						bad_q  <= 1'b0;
						vld_q  <= 1'b1;
						if (idx_q == '0) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - AW'(1);
							st_q  <= ST_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = M_TDATA_W'(char_q);
	assign m_tlast  = last_q;
	assign m_tuser  = bad_q;

endmodule

`default_nettype wire

/* rtl/radix_digit_converter_core.sv */
// ----------------------------------------------------------------------------
// radix_digit_converter_core
// Converts an unsigned value to ASCII digits in radix 2..16, most significant
// digit first, with the last character marked and bad radix flagged.
// ----------------------------------------------------------------------------
// Timing: an input word passes the queue, then the divider runs one division per
//   digit, and the digits are read back through the RAM and the output register;
//   a bad radix word goes from the queue straight into the output register.
//   The engine takes the next number only after its last character is loaded.
// Reset: arst_n clears the queue, sequencer and output valid; the digit RAM is
//   not cleared and needs no clearing pass.
`default_nettype none

module radix_digit_converter_core
	import rdc_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [S_TDATA_W-1:0]  s_tdata,   // value[31:0], radix[36:32], zero pad
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // digit_char[6:0], zero pad
	output logic                  m_tlast,   // last
	output logic                  m_tuser    // bad_radix
);

	logic                  q_valid;
	logic                  q_pop;
	logic [VALUE_BITS-1:0] q_value;
	rdc_cls_t              q_cls;

	// input side and queue
	rdc_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_value  (q_value),
		.q_cls    (q_cls)
	);

	// conversion engine
	rdc_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_value  (q_value),
		.q_cls    (q_cls),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
